>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the point plotter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define PPCD_ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define PPCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ppcd_pkg.sv
// ----------------------------------------------------------------------------
// ppcd_pkg
// Types, constants and helper functions of the point plotter.
// ----------------------------------------------------------------------------
package ppcd_pkg;

  // Geometry and field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_W          = 13;
  localparam int STRIDE_W       = 8;
  localparam int ADDR_W         = 24;
  localparam int PIX_W          = 32;
  localparam int CFG_W          = 13;
  localparam int PHASE_W        = 7;
  localparam int VEL_W          = 4;
  localparam int HOLD_W         = 9;
  localparam int CH_W           = 11;

  // Reset values
  localparam logic [DIM_W-1:0]    WIDTH_RST   = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST  = 13'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RST  = 8'd1;
  localparam logic [PIX_W-1:0]    COLOR_RST   = 32'hc0c0c0c0;
  localparam logic signed [VEL_W-1:0] VEL_B_RST = 4'sd2;
  localparam logic signed [VEL_W-1:0] VEL_G_RST = 4'sd4;
  localparam logic signed [VEL_W-1:0] VEL_R_RST = 4'sd3;
  localparam logic signed [VEL_W-1:0] VEL_A_RST = 4'sd2;
  localparam logic signed [HOLD_W-1:0] HOLD_SET = 9'sd250;
  localparam logic [PHASE_W-1:0]  PHASE_LAST  = 7'd79;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_POINT_STRIDE = 2'd2
  } cfg_reg_t;

  // Item kinds
  typedef enum logic [1:0] {
    OP_POINT       = 2'd0,
    OP_FRAME_START = 2'd1,
    OP_FRAME_END   = 2'd2
  } op_t;

  // Palette modes
  typedef enum logic [1:0] {
    MODE_SEA  = 2'd0,
    MODE_FIRE = 2'd1,
    MODE_MIX  = 2'd2
  } mode_t;

  // Random fields that steer one color walk
  typedef struct packed {
    logic [1:0] rnd_blue;
    logic [1:0] rnd_green;
    logic [1:0] rnd_red;
    logic [1:0] rnd_alpha;
    logic       change_hit;
    logic [1:0] mode_pick;
  } walk_rnd_t;

  // Brightness shift: ramps 0..3 over phases 0..39 and back down
  function automatic logic [1:0] phase_shift(input logic [PHASE_W-1:0] phase);
    logic [1:0] sh;
    if (phase < 7'd10)      sh = 2'd0;
    else if (phase < 7'd20) sh = 2'd1;
    else if (phase < 7'd30) sh = 2'd2;
    else if (phase < 7'd50) sh = 2'd3;
    else if (phase < 7'd60) sh = 2'd2;
    else if (phase < 7'd70) sh = 2'd1;
    else                    sh = 2'd0;
    return sh;
  endfunction

endpackage

>>> rtl/core/ppcd_color_walk.sv
// ----------------------------------------------------------------------------
// ppcd_color_walk
// Draw color state and its bounded random walk at each frame end.
// ----------------------------------------------------------------------------
module ppcd_color_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ppcd_pkg::walk_rnd_t rnd,
  output logic [31:0]         color
);
  import ppcd_pkg::*;

  logic [PIX_W-1:0]         color_r, color_nxt;
  logic signed [VEL_W-1:0]  vb_r, vg_r, vr_r, va_r;
  logic signed [VEL_W-1:0]  vb_nxt, vg_nxt, vr_nxt, va_nxt;
  mode_t                    mode_r, mode_nxt;
  logic signed [HOLD_W-1:0] hold_r, hold_nxt;

  logic signed [CH_W-1:0]  b, g, r, a;
  logic signed [VEL_W-1:0] pb, pg, pr, pa;
  logic                    chg;

  // Work out the next color, velocities, mode and hold-off
  always_comb begin
    b  = signed'({3'b000, color_r[7:0]});
    g  = signed'({3'b000, color_r[15:8]});
    r  = signed'({3'b000, color_r[23:16]});
    a  = signed'({3'b000, color_r[31:24]});
    vb_nxt = vb_r;
    vg_nxt = vg_r;
    vr_nxt = vr_r;
    va_nxt = va_r;
    mode_nxt = mode_r;
    chg = 1'b0;
    pb = signed'({2'b00, rnd.rnd_blue}) + 4'sd1;
    pg = signed'({2'b00, rnd.rnd_green}) + 4'sd2;
    pr = signed'({2'b00, rnd.rnd_red}) + 4'sd1;
    pa = signed'({2'b00, rnd.rnd_alpha}) + 4'sd1;

    hold_nxt = hold_r;
    if (hold_r > -9'sd1) hold_nxt = hold_r - 9'sd1;

    case (mode_r)
      MODE_SEA: begin
        b = b + {{7{vb_nxt[3]}}, vb_nxt};
        if (b > 11'sd255) begin b = 11'sd255; vb_nxt = -pb; end
        if (b < 11'sd32)  begin b = 11'sd32;  vb_nxt = pb;  end
        g = g + {{7{vg_nxt[3]}}, vg_nxt};
        if (g > 11'sd200) begin g = 11'sd200; vg_nxt = -pg;    end
        if (g > b)        begin g = b;        vg_nxt = vb_nxt; end
        if (g < 11'sd32)  begin g = 11'sd32;  vg_nxt = pg;     end
        r = r + {{7{vr_nxt[3]}}, vr_nxt};
        if (r > 11'sd64) begin r = 11'sd64; vr_nxt = -pr; end
        if (r < 11'sd0)  begin r = 11'sd0;  vr_nxt = pr;  end
        a = a + {{7{va_nxt[3]}}, va_nxt};
        if (a > 11'sd0) begin a = 11'sd0; va_nxt = -pa; end
        if (a < 11'sd0) begin a = 11'sd0; va_nxt = pa;  end
        chg = (g > 11'sd32) && (r < g + 11'sd40) && (g < r + 11'sd20) && (b < 11'sd64);
        if (chg && rnd.change_hit && hold_nxt < 9'sd0) begin
          mode_nxt = (rnd.mode_pick != 2'd0) ? MODE_FIRE : MODE_MIX;
          hold_nxt = HOLD_SET;
        end
      end
      MODE_MIX: begin
        b = b + {{7{vb_nxt[3]}}, vb_nxt};
        if (b > 11'sd128) begin b = 11'sd128; vb_nxt = -pb; end
        if (b < 11'sd16)  begin b = 11'sd16;  vb_nxt = pb;  end
        g = g + {{7{vg_nxt[3]}}, vg_nxt};
        if (g > 11'sd200) begin g = 11'sd200; vg_nxt = -pg;    end
        if (g > a)        begin g = a;        vg_nxt = va_nxt; end
        if (g < 11'sd32)  begin g = 11'sd32;  vg_nxt = pg;     end
        r = r + {{7{vr_nxt[3]}}, vr_nxt};
        if (r > 11'sd128) begin r = 11'sd128; vr_nxt = -pr; end
        if (r < 11'sd0)   begin r = 11'sd0;   vr_nxt = pr;  end
        a = a + {{7{va_nxt[3]}}, va_nxt};
        if (a > 11'sd255) begin a = 11'sd255; va_nxt = -pa; end
        if (a < 11'sd0)   begin a = 11'sd0;   va_nxt = pa;  end
        chg = (g > 11'sd32) && (r < g + 11'sd40) && (g < r + 11'sd20) && (b < 11'sd64);
        if (chg && rnd.change_hit && hold_nxt < 9'sd0) begin
          mode_nxt = (rnd.mode_pick != 2'd0) ? MODE_FIRE : MODE_SEA;
          hold_nxt = HOLD_SET;
        end
      end
      MODE_FIRE: begin
        b = b + {{7{vb_nxt[3]}}, vb_nxt};
        if (b > 11'sd64) begin b = 11'sd64; vb_nxt = -pb; end
        if (b < 11'sd0)  begin b = 11'sd0;  vb_nxt = pb;  end
        g = g + {{7{vg_nxt[3]}}, vg_nxt};
        if (g > 11'sd200) begin g = 11'sd200; vg_nxt = -pg; end
        if (g > r + 11'sd20) begin
          g = r + 11'sd20;
          vg_nxt = -pg;
          vr_nxt = pr;
          vb_nxt = pb;
        end
        if (g < 11'sd0) begin g = 11'sd0; vg_nxt = pg; end
        r = r + {{7{vr_nxt[3]}}, vr_nxt};
        if (r > 11'sd255)     begin r = 11'sd255;     vr_nxt = -pr; end
        if (r > g + 11'sd40)  begin r = g + 11'sd40;  vr_nxt = -pr; end
        if (r < 11'sd0)       begin r = 11'sd0;       vr_nxt = pr;  end
        a = a + {{7{va_nxt[3]}}, va_nxt};
        if (a > 11'sd0) begin a = 11'sd0; va_nxt = -pa; end
        if (a < 11'sd0) begin a = 11'sd0; va_nxt = pa;  end
        chg = (r < 11'sd64) && (g > 11'sd32) && (g < b) && (b > 11'sd32);
        if (chg && rnd.change_hit && hold_nxt < 9'sd0) begin
          mode_nxt = (rnd.mode_pick != 2'd0) ? MODE_SEA : MODE_MIX;
          hold_nxt = HOLD_SET;
        end
      end
      default: begin
        // unknown mode: colors and velocities hold
      end
    endcase

    color_nxt = {a[7:0], r[7:0], g[7:0], b[7:0]};
  end

  // Update the walk state on a frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RST;
      vb_r    <= VEL_B_RST;
      vg_r    <= VEL_G_RST;
      vr_r    <= VEL_R_RST;
      va_r    <= VEL_A_RST;
      mode_r  <= MODE_MIX;
      hold_r  <= '0;
    end else if (step) begin
      color_r <= color_nxt;
      vb_r    <= vb_nxt;
      vg_r    <= vg_nxt;
      vr_r    <= vr_nxt;
      va_r    <= va_nxt;
      mode_r  <= mode_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign color = color_r;

endmodule

>>> rtl/core/ppcd_point_blend.sv
// ----------------------------------------------------------------------------
// ppcd_point_blend
// Frame phase, point stride selection, clipping, addressing and blending.
// ----------------------------------------------------------------------------
module ppcd_point_blend #(
  parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          point_step,
  input  logic                          frame_start,
  input  logic [COORD_BITS-1:0]         point_x,
  input  logic [COORD_BITS-1:0]         point_y,
  input  logic [ppcd_pkg::PIX_W-1:0]    back_pixel,
  input  logic [ppcd_pkg::PIX_W-1:0]    color,
  input  logic [ppcd_pkg::DIM_W-1:0]    frame_width,
  input  logic [ppcd_pkg::DIM_W-1:0]    frame_height,
  input  logic [ppcd_pkg::STRIDE_W-1:0] point_stride,
  output logic                          keep,
  output logic [ppcd_pkg::ADDR_W-1:0]   pixel_address,
  output logic [ppcd_pkg::PIX_W-1:0]    pixel_value
);
  import ppcd_pkg::*;

  localparam int PROD_W = COORD_BITS + DIM_W;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [STRIDE_W-1:0] cnt_r, cnt_nxt;
  logic [STRIDE_W-1:0] stride_eff;
  logic [STRIDE_W:0]   cnt_inc;
  logic [1:0]          shift;
  logic                in_frame;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     sum;

  // Advance the frame phase, wrapping after the last phase
  assign phase_nxt = (phase_r >= PHASE_LAST) ? 7'd1 : phase_r + 7'd1;

  // Stride count: zero stride acts as one
  assign stride_eff = (point_stride == '0) ? 8'd1 : point_stride;
  assign cnt_inc    = {1'b0, cnt_r} + 9'd1;
  assign cnt_nxt    = (cnt_inc >= {1'b0, stride_eff}) ? '0 : cnt_inc[STRIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
    end else if (frame_start) begin
      phase_r <= phase_nxt;
      cnt_r   <= '0;
    end else if (point_step) begin
      cnt_r   <= cnt_nxt;
    end
  end

  // Clip against the frame and pick the stride-th point
  assign in_frame = (PROD_W'(point_x) < PROD_W'(frame_width)) &&
                    (PROD_W'(point_y) < PROD_W'(frame_height));
  assign keep     = (cnt_r == '0) && in_frame;

  // Pixel address: row times frame width plus column
  assign prod          = PROD_W'(point_y) * PROD_W'(frame_width);
  assign sum           = {1'b0, prod} + (PROD_W + 1)'(point_x);
  assign pixel_address = ADDR_W'(sum);

  // Blend each byte with saturation
  assign shift = phase_shift(phase_r);

  always_comb begin
    logic [8:0] s;
    pixel_value = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, color[8*i +: 8] >> shift} + {1'b0, back_pixel[8*i +: 8]};
      pixel_value[8*i +: 8] = s[8] ? 8'hff : s[7:0];
    end
  end

endmodule

>>> rtl/core/point_plot_color_drift.sv
// ----------------------------------------------------------------------------
// point_plot_color_drift
// Plots stride-selected points with a drifting, phase-dimmed color.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  in_*      | slave     | tuser: opcode; tdata: point, background, randoms
//  out_*     | master    | tdata: pixel_address, pixel_value
//  cfg_*     | write     | frame_width, frame_height, point_stride
//
//  One item per cycle while the result side takes them; a kept point moves
//  from the input register through the y*width multiply and blend, as logic
//  in front of the result register, with the draw color from the color walk.
//  Reset (rst_n low, synchronous) restores the draw color, velocities,
//  palette mode, frame phase, stride count and registers.
//  A stalled result holds in the output register; the input register
//  still takes an item while it is empty or its own item can move on.
// ----------------------------------------------------------------------------
module point_plot_color_drift #(
  parameter int COORD_BITS = ppcd_pkg::COORD_BITS_DEF,
  localparam int IN_DATA_W = ((2 * COORD_BITS + 43 + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // point_x, point_y, back_pixel, rnd_blue, rnd_green, rnd_red, rnd_alpha,
  // change_hit, mode_pick, zero fill
  input  logic [IN_DATA_W-1:0]        in_tdata,
  // opcode
  input  logic [1:0]                  in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // pixel_address, pixel_value
  output logic [55:0]                 out_tdata,
  // configuration
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ppcd_pkg::CFG_W-1:0]  cfg_wdata
);
  import ppcd_pkg::*;

  localparam int X_LO = 0;
  localparam int Y_LO = COORD_BITS;
  localparam int B_LO = 2 * COORD_BITS;
  localparam int R_LO = B_LO + PIX_W;

  logic [DIM_W-1:0]    width_r, height_r;
  logic [STRIDE_W-1:0] stride_r;

  logic                s1_v_r;
  op_t                 s1_op_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [PIX_W-1:0]    s1_back_r;
  walk_rnd_t           s1_rnd_r;

  logic                out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [PIX_W-1:0]    out_pix_r;

  logic                advance;
  logic                keep;
  logic [ADDR_W-1:0]   addr;
  logic [PIX_W-1:0]    pix;
  logic [PIX_W-1:0]    color;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      stride_r <= STRIDE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        REG_POINT_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake
  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_x_r    <= in_tdata[X_LO +: COORD_BITS];
      s1_y_r    <= in_tdata[Y_LO +: COORD_BITS];
      s1_back_r <= in_tdata[B_LO +: PIX_W];
      s1_rnd_r  <= '{rnd_blue:   in_tdata[R_LO +: 2],
                     rnd_green:  in_tdata[R_LO + 2 +: 2],
                     rnd_red:    in_tdata[R_LO + 4 +: 2],
                     rnd_alpha:  in_tdata[R_LO + 6 +: 2],
                     change_hit: in_tdata[R_LO + 8],
                     mode_pick:  in_tdata[R_LO + 9 +: 2]};
    end
  end

  // Color walk on frame end
  ppcd_color_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance && (s1_op_r == OP_FRAME_END)),
    .rnd   (s1_rnd_r),
    .color (color)
  );

  // Point selection and blending
  ppcd_point_blend #(
    .COORD_BITS (COORD_BITS)
  ) u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .point_step    (advance && (s1_op_r == OP_POINT)),
    .frame_start   (advance && (s1_op_r == OP_FRAME_START)),
    .point_x       (s1_x_r),
    .point_y       (s1_y_r),
    .back_pixel    (s1_back_r),
    .color         (color),
    .frame_width   (width_r),
    .frame_height  (height_r),
    .point_stride  (stride_r),
    .keep          (keep),
    .pixel_address (addr),
    .pixel_value   (pix)
  );

  // Result register
  assign out_v_nxt = (out_v_r && !out_tready) ||
                     (advance && (s1_op_r == OP_POINT) && keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_op_r == OP_POINT) && keep) begin
      out_addr_r <= addr;
      out_pix_r  <= pix;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_pix_r, out_addr_r};

endmodule

>>> rtl/core/ppcd_checker.sv
// ----------------------------------------------------------------------------
// ppcd_checker
// Port-level checks on the point plotter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A stalled result keeps its payload
  `PPCD_ASSERT_ON(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Reset empties the result register
  `PPCD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // With the result register empty, the input side never stalls
  `PPCD_ASSERT_ON(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")

endmodule

bind point_plot_color_drift ppcd_checker u_ppcd_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for point_plot_color_drift. Sends frame starts, points
// and frame ends through the input stream and predicts every kept point's
// address and blended pixel with its own copy of the color walk. It compares
// each result transfer with the oldest prediction. Both stream sides idle at
// random, and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import ppcd_pkg::*;

  localparam int ITEM_W = 72;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_PRINTS = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ITEM_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // both sides run without idle cycles while set
  bit steady = 1'b0;
  // ask the result side for one long hold-off
  bit burst_hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Predicts kept points and holds the pixels still due on the result stream
  // --------------------------------------------------------------------------
  class plot_tracker;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [PIX_W-1:0] tint;
    logic signed [VEL_W-1:0] vel_b, vel_g, vel_r, vel_a;
    mode_t palette;
    logic signed [HOLD_W-1:0] holdoff;
    int phase;
    int run_count;
    // pixel_value in the upper bits, pixel_address in the lower
    logic [55:0] pixels_due[$];
    int mismatches;

    function new();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      stride_reg = STRIDE_RST;
      tint = COLOR_RST;
      vel_b = VEL_B_RST;
      vel_g = VEL_G_RST;
      vel_r = VEL_R_RST;
      vel_a = VEL_A_RST;
      palette = MODE_MIX;
      holdoff = '0;
      phase = 0;
      run_count = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void write_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = val[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
        REG_POINT_STRIDE: stride_reg = val[STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    // brightness shift: ramps up over the first half of the phase cycle
    function int dim_shift();
      if (phase < 40)
        return phase / 10;
      return 7 - phase / 10;
    endfunction

    // bounded walk of the four channels, one step per frame end
    function void walk_colors(logic [ITEM_W-1:0] bits);
      int b, g, r, a, vb, vg, vr, va, rb, rg, rr, ra;
      bit hit, pick;
      b = int'(tint[7:0]);
      g = int'(tint[15:8]);
      r = int'(tint[23:16]);
      a = int'(tint[31:24]);
      vb = int'(vel_b);
      vg = int'(vel_g);
      vr = int'(vel_r);
      va = int'(vel_a);
      rb = int'(bits[57:56]);
      rg = int'(bits[59:58]);
      rr = int'(bits[61:60]);
      ra = int'(bits[63:62]);
      hit = bits[64];
      pick = (bits[66:65] != 2'd0);

      if (holdoff > -1)
        holdoff = holdoff - 9'sd1;

      case (palette)
        MODE_SEA: begin
          b += vb;
          if (b > 255) begin b = 255; vb = -rb - 1; end
          if (b < 32) begin b = 32; vb = rb + 1; end
          g += vg;
          if (g > 200) begin g = 200; vg = -rg - 2; end
          if (g > b) begin g = b; vg = vb; end
          if (g < 32) begin g = 32; vg = rg + 2; end
          r += vr;
          if (r > 64) begin r = 64; vr = -rr - 1; end
          if (r < 0) begin r = 0; vr = rr + 1; end
          a += va;
          if (a > 0) begin a = 0; va = -ra - 1; end
          if (a < 0) begin a = 0; va = ra + 1; end
          if (g > 32 && r < g + 40 && g < r + 20 && b < 64 && hit && holdoff < 0) begin
            palette = pick ? MODE_FIRE : MODE_MIX;
            holdoff = HOLD_SET;
          end
        end
        MODE_MIX: begin
          b += vb;
          if (b > 128) begin b = 128; vb = -rb - 1; end
          if (b < 16) begin b = 16; vb = rb + 1; end
          g += vg;
          if (g > 200) begin g = 200; vg = -rg - 2; end
          if (g > a) begin g = a; vg = va; end
          if (g < 32) begin g = 32; vg = rg + 2; end
          r += vr;
          if (r > 128) begin r = 128; vr = -rr - 1; end
          if (r < 0) begin r = 0; vr = rr + 1; end
          a += va;
          if (a > 255) begin a = 255; va = -ra - 1; end
          if (a < 0) begin a = 0; va = ra + 1; end
          if (g > 32 && r < g + 40 && g < r + 20 && b < 64 && hit && holdoff < 0) begin
            palette = pick ? MODE_FIRE : MODE_SEA;
            holdoff = HOLD_SET;
          end
        end
        MODE_FIRE: begin
          b += vb;
          if (b > 64) begin b = 64; vb = -rb - 1; end
          if (b < 0) begin b = 0; vb = rb + 1; end
          g += vg;
          if (g > 200) begin g = 200; vg = -rg - 2; end
          // green more than 20 above red: push green down, red and blue up
          if (g > r + 20) begin
            g = r + 20;
            vg = -rg - 2;
            vr = rr + 1;
            vb = rb + 1;
          end
          if (g < 0) begin g = 0; vg = rg + 2; end
          r += vr;
          if (r > 255) begin r = 255; vr = -rr - 1; end
          if (r > g + 40) begin r = g + 40; vr = -rr - 1; end
          if (r < 0) begin r = 0; vr = rr + 1; end
          a += va;
          if (a > 0) begin a = 0; va = -ra - 1; end
          if (a < 0) begin a = 0; va = ra + 1; end
          if (r < 64 && g > 32 && g < b && b > 32 && hit && holdoff < 0) begin
            palette = pick ? MODE_SEA : MODE_MIX;
            holdoff = HOLD_SET;
          end
        end
        default: ;  // no walk in an unknown mode
      endcase

      vel_b = VEL_W'(vb);
      vel_g = VEL_W'(vg);
      vel_r = VEL_W'(vr);
      vel_a = VEL_W'(va);
      tint = {a[7:0], r[7:0], g[7:0], b[7:0]};
    endfunction

    // stride selection, clipping and the saturated blend of one point
    function void plot_point(logic [ITEM_W-1:0] bits);
      logic [11:0] x, y;
      logic [31:0] back, pix;
      int stride, sh, c, s;
      int unsigned spot;
      bit chosen;
      x = bits[11:0];
      y = bits[23:12];
      back = bits[55:24];
      stride = (stride_reg == 0) ? 1 : int'(stride_reg);
      chosen = (run_count == 0);
      sh = dim_shift();
      run_count++;
      if (run_count >= stride)
        run_count = 0;
      if (!chosen || x >= width_reg || y >= height_reg)
        return;
      for (int i = 0; i < 4; i++) begin
        c = int'(tint[8*i +: 8]) >> sh;
        s = c + int'(back[8*i +: 8]);
        if (s > 255)
          s = 255;
        pix[8*i +: 8] = s[7:0];
      end
      spot = int'(y) * int'(width_reg) + int'(x);
      pixels_due.push_back({pix, spot[23:0]});
    endfunction

    // note one input transfer
    function void take_item(logic [1:0] op, logic [ITEM_W-1:0] bits);
      case (op)
        OP_FRAME_START: begin
          phase = (phase >= PHASE_LAST) ? 1 : phase + 1;
          run_count = 0;
        end
        OP_FRAME_END: walk_colors(bits);
        OP_POINT: plot_point(bits);
        default: ;  // unused opcode: ignored
      endcase
    endfunction

    // check one result transfer against the oldest prediction
    task match_pixel(logic [55:0] got);
      logic [55:0] want;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result addr %h pixel %h",
                                  got[23:0], got[55:24]));
        return;
      end
      want = pixels_due.pop_front();
      if (got[23:0] !== want[23:0])
        report_mismatch($sformatf("pixel_address %h, want %h", got[23:0], want[23:0]));
      if (got[55:24] !== want[55:24])
        report_mismatch($sformatf("pixel_value %h, want %h (addr %h)",
                                  got[55:24], want[55:24], want[23:0]));
    endtask
  endclass

  plot_tracker tracker;

  point_plot_color_drift uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pack the item fields, point_x in the lowest bits
  function automatic logic [ITEM_W-1:0] item_bits(logic [11:0] x, logic [11:0] y,
                                                  logic [31:0] back, logic [1:0] rb,
                                                  logic [1:0] rg, logic [1:0] rr,
                                                  logic [1:0] ra, logic hit,
                                                  logic [1:0] pick);
    return {5'b0, pick, hit, ra, rr, rg, rb, back, y, x};
  endfunction

  function automatic logic [ITEM_W-1:0] random_bits();
    logic [11:0] x, y;
    logic [1:0] rb, rg, rr, ra, pick;
    logic hit;
    x = 12'($urandom_range(0, 4095));
    y = 12'($urandom_range(0, 4095));
    rb = 2'($urandom_range(0, 3));
    rg = 2'($urandom_range(0, 3));
    rr = 2'($urandom_range(0, 3));
    ra = 2'($urandom_range(0, 3));
    pick = 2'($urandom_range(0, 3));
    hit = 1'($urandom_range(0, 1));
    return item_bits(x, y, $urandom, rb, rg, rr, ra, hit, pick);
  endfunction

  // coordinate mostly inside the frame, sometimes on its edge or anywhere
  function automatic logic [11:0] pick_coord(int unsigned limit);
    int unsigned top;
    logic [11:0] v;
    top = (limit > 4096) ? 4096 : limit;
    case ($urandom_range(0, 9))
      0, 1: v = 12'($urandom_range(0, 4095));
      2: v = (top >= 4096) ? 12'd4095 : 12'(top - 1 + $urandom_range(0, 1));
      default: v = 12'($urandom_range(0, top - 1));
    endcase
    return v;
  endfunction

  // offer one item after a random gap, hold it until the transfer
  task automatic send_item(logic [1:0] op, logic [ITEM_W-1:0] bits);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= bits;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.take_item(op, bits);
  endtask

  task automatic send_point_near();
    logic [ITEM_W-1:0] bits;
    bits = random_bits();
    bits[11:0] = pick_coord(tracker.width_reg);
    bits[23:12] = pick_coord(tracker.height_reg);
    send_item(OP_POINT, bits);
  endtask

  task automatic set_reg(cfg_reg_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned s);
    set_reg(REG_FRAME_WIDTH, w);
    set_reg(REG_FRAME_HEIGHT, h);
    set_reg(REG_POINT_STRIDE, s);
  endtask

  // drop valid and wait until every predicted pixel is out and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // frames of random content: at times a stray item, then start, points and none, one or a burst of frame ends
  task automatic run_frames(int budget);
    int sent, n, k;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 19))
        0: send_item(OP_UNUSED, random_bits());
        1: begin
          send_point_near();
          sent++;
        end
        2: begin
          send_item(OP_FRAME_END, random_bits());
          sent++;
        end
        default: ;
      endcase
      send_item(OP_FRAME_START, random_bits());
      sent++;
      n = $urandom_range(0, 12);
      repeat (n) begin
        send_point_near();
        sent++;
      end
      if ($urandom_range(0, 9) == 0)
        k = $urandom_range(10, 40);
      else
        k = ($urandom_range(0, 9) == 0) ? 0 : 1;
      repeat (k) begin
        send_item(OP_FRAME_END, random_bits());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int pause;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (burst_hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      pause = steady ? 0 : $urandom_range(0, 19);
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      tracker.match_pixel(out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w3, h3, s3;
    int guard;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: corners, clipping, saturation, unused opcode
    send_item(OP_POINT, item_bits(12'd0, 12'd0, 32'h0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd639, 12'd479, 32'hffffffff, 2'd3, 2'd3, 2'd3, 2'd3,
                                  1'b1, 2'd3));
    send_item(OP_POINT, item_bits(12'd640, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd0, 12'd480, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_UNUSED, random_bits());
    send_item(OP_FRAME_START, random_bits());
    send_item(OP_POINT, item_bits(12'd100, 12'd200, 32'h3f7f01fe, 2'd0, 2'd0, 2'd0, 2'd0,
                                  1'b0, 2'd0));
    // all randoms at three, then all-zero randoms
    send_item(OP_FRAME_END, item_bits(12'd0, 12'd0, 32'h0, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 2'd3));
    send_item(OP_FRAME_END, item_bits(12'hfff, 12'hfff, 32'hffffffff, 2'd0, 2'd0, 2'd0, 2'd0,
                                      1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd4095, 12'd4095, $urandom, 2'd0, 2'd0, 2'd0, 2'd0,
                                  1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd1, 12'd1, 32'h80808080, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    settle();

    // largest frame, zero stride acts as one
    configure(4096, 4096, 0);
    send_item(OP_POINT, item_bits(12'd4095, 12'd4095, $urandom, 2'd1, 2'd2, 2'd1, 2'd2,
                                  1'b0, 2'd1));
    send_item(OP_POINT, item_bits(12'd0, 12'd4095, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_FRAME_START, random_bits());
    send_item(OP_POINT, item_bits(12'd4095, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    settle();

    // one-pixel frame; clipped points still advance the stride count
    configure(1, 1, 5);
    send_item(OP_FRAME_START, random_bits());
    send_item(OP_POINT, item_bits(12'd0, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd1, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd0, 12'd1, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    settle();

    // lower the stride below the running count mid-frame
    set_reg(REG_POINT_STRIDE, 2);
    send_item(OP_POINT, item_bits(12'd0, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd0, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd5, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    send_item(OP_POINT, item_bits(12'd0, 12'd0, $urandom, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 2'd0));
    settle();

    // random frames; the long result hold-off falls in the first setting
    configure(640, 480, 1);
    run_frames(150);
    burst_hold_req = 1'b1;
    run_frames(350);
    settle();

    configure(4096, 4096, 3);
    steady = 1'b1;
    run_frames(150);
    steady = 1'b0;
    run_frames(200);
    settle();

    w3 = $urandom_range(1, 4096);
    h3 = $urandom_range(1, 4096);
    s3 = $urandom_range(1, 8);
    configure(w3, h3, s3);
    run_frames(300);
    settle();

    configure(1, 1, 1);
    run_frames(100);
    settle();

    configure(37, 4096, 255);
    run_frames(200);
    settle();

    configure(4096, 1, 2);
    run_frames(300);

    // drain with a limit, then check for leftovers
    in_tvalid <= 1'b0;
    guard = 0;
    while (tracker.pixels_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (tracker.pixels_due.size() != 0)
      tracker.report_mismatch($sformatf("%0d predicted results never arrived",
                                        tracker.pixels_due.size()));
    if (tracker.mismatches == 0)
      $display("** point_plot_color_drift: PASSED **");
    else
      $display("** point_plot_color_drift: FAILED **");
    $finish;
  end

  // hard stop for a hung run
  initial begin : watchdog
    #(10_000_000);
    $display("** point_plot_color_drift: FAILED **");
    $finish;
  end

endmodule
